// ===== sv/pls_pkg.sv =====
// pls_pkg: shared types and codes for the positional list store
// operation and status codes, decoded command type and the front-to-back command record
// no dependencies
`default_nettype none

package pls_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;
  localparam int COUNT_W = 9;
  localparam int QUEUE_DEPTH = 2;

  // operation codes on the input port
  localparam logic [2:0] OP_INS_END  = 3'd0;
  localparam logic [2:0] OP_INS_HEAD = 3'd1;
  localparam logic [2:0] OP_INS_POS  = 3'd2;
  localparam logic [2:0] OP_DEL_HEAD = 3'd3;
  localparam logic [2:0] OP_DEL_END  = 3'd4;
  localparam logic [2:0] OP_DEL_POS  = 3'd5;

  // status codes on the result port
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    CMD_INS_END,
    CMD_INS_HEAD,
    CMD_INS_POS,
    CMD_DEL_HEAD,
    CMD_DEL_END,
    CMD_DEL_POS,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;
    logic                       pos_low;   // position is 0 or 1
    logic                       pos_zero;
  } pls_cmd_t;

endpackage

`default_nettype wire

// ===== sv/pls_front.sv =====
// pls_front: decodes an incoming item into a command record
// depends on pls_pkg
`default_nettype none

module pls_front (
  input  wire logic [2:0]                       operation,
  input  wire logic signed [pls_pkg::VALUE_W-1:0] value,
  input  wire logic [pls_pkg::POS_W-1:0]        position,
  output pls_pkg::pls_cmd_t                     cmd
);
  import pls_pkg::*;

  always_comb begin
    cmd.value    = value;
    cmd.position = position;
    cmd.pos_zero = (position == '0);
    cmd.pos_low  = (position <= POS_W'(1));
    unique case (operation)
      OP_INS_END:  cmd.kind = CMD_INS_END;
      OP_INS_HEAD: cmd.kind = CMD_INS_HEAD;
      OP_INS_POS:  cmd.kind = CMD_INS_POS;
      OP_DEL_HEAD: cmd.kind = CMD_DEL_HEAD;
      OP_DEL_END:  cmd.kind = CMD_DEL_END;
      OP_DEL_POS:  cmd.kind = CMD_DEL_POS;
      default:     cmd.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/pls_queue.sv =====
// pls_queue: two-entry command queue between the front and the back
// depends on pls_pkg
`default_nettype none

module pls_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  pls_pkg::pls_cmd_t  wr_cmd,
  output logic               full,
  input  wire logic          rd,
  output logic               valid,
  output pls_pkg::pls_cmd_t  rd_cmd
);
  import pls_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pls_cmd_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign valid  = (count != '0);
  assign rd_cmd = slots[rptr];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + PTR_W'(1);
      if (do_rd) rptr <= rptr + PTR_W'(1);
      priority if (do_wr && !do_rd) count <= count + CNT_W'(1);
      else if (do_rd && !do_wr) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wptr] <= wr_cmd;
  end

endmodule

`default_nettype wire

// ===== sv/pls_back.sv =====
// pls_back: shift-cell list storage, command execution and result register
// depends on pls_pkg
`default_nettype none

module pls_back #(
  parameter int DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  input  pls_pkg::pls_cmd_t                      cmd,
  output logic                                   cmd_take,
  output logic                                   res_valid,
  input  wire logic                              res_pop,
  output logic [1:0]                             res_status,
  output logic signed [pls_pkg::VALUE_W-1:0]     res_removed,
  output logic [pls_pkg::COUNT_W-1:0]            res_count
);
  import pls_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VALUE_W-1:0] cells [DEPTH];
  logic [CW-1:0]             occ;
  logic [CW-1:0]             occ_next;

  logic          do_ins;
  logic          do_del;
  logic [IW-1:0] idx;
  logic [1:0]    status;
  logic          is_full;
  logic          is_empty;
  logic          pos_over;   // position beyond the count

  assign cmd_take = cmd_valid && (!res_valid || res_pop);
  assign is_full  = (occ == CW'(DEPTH));
  assign is_empty = (occ == '0);
  assign pos_over = (cmd.position > POS_W'(occ));

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    status = ST_OK;
    unique case (cmd.kind)
      CMD_INS_END, CMD_INS_HEAD, CMD_INS_POS: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          priority if (cmd.kind == CMD_INS_END) idx = IW'(occ);
          else if (cmd.kind == CMD_INS_HEAD || is_empty || cmd.pos_low) idx = '0;
          else if (pos_over) idx = IW'(occ);
          else idx = IW'(cmd.position - POS_W'(1));
        end
      end
      CMD_DEL_HEAD, CMD_DEL_END, CMD_DEL_POS: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (cmd.kind == CMD_DEL_HEAD) begin
          do_del = 1'b1;
        end else if (cmd.kind == CMD_DEL_END) begin
          do_del = 1'b1;
          idx    = IW'(occ - CW'(1));
        end else if (cmd.pos_zero || pos_over) begin
          status = ST_RANGE;
        end else begin
          do_del = 1'b1;
          idx    = IW'(cmd.position - POS_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    occ_next = occ;
    if (do_ins) occ_next = occ + CW'(1);
    else if (do_del) occ_next = occ - CW'(1);
  end

  // every cell picks its own, new, left or right value in parallel
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left;
    logic signed [VALUE_W-1:0] right;
    logic signed [VALUE_W-1:0] cell_next;

    if (g == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_mid
      assign left = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cells[g];
    end else begin : g_inner
      assign right = cells[g+1];
    end

    always_comb begin
      cell_next = cells[g];
      if (do_ins) begin
        if (IW'(g) == idx) cell_next = cmd.value;
        else if (IW'(g) > idx) cell_next = left;
      end else if (do_del) begin
        if (IW'(g) >= idx) cell_next = right;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd_take && (do_ins || do_del)) cells[g] <= cell_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        occ       <= occ_next;
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      res_status  <= status;
      res_removed <= do_del ? cells[idx] : '0;
      res_count   <= COUNT_W'(occ_next);
    end
  end

endmodule

`default_nettype wire

// ===== sv/positional_list_store.sv =====
// positional_list_store: ordered list with insert and delete at head, end or position
// accepted items pass the command queue, then the result register, to the result ports
// one item per cycle unless the result side stalls; all list cells shift in parallel
// a two-entry command queue parts the decode front from the list back
// reset (rst, synchronous) clears list, queue and result; stored values stay undefined
// depends on pls_pkg, pls_front, pls_queue, pls_back
`default_nettype none

module positional_list_store #(
  parameter int DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [2:0]                        operation,
  input  wire logic signed [pls_pkg::VALUE_W-1:0] value,
  input  wire logic [pls_pkg::POS_W-1:0]         position,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [1:0]                             status,
  output logic signed [pls_pkg::VALUE_W-1:0]     removed_value,
  output logic [pls_pkg::COUNT_W-1:0]            entry_count
);
  import pls_pkg::*;

  pls_cmd_t front_cmd;
  pls_cmd_t back_cmd;
  logic     q_valid;
  logic     q_take;
  logic     res_valid;

  pls_front u_front (
    .operation (operation),
    .value     (value),
    .position  (position),
    .cmd       (front_cmd)
  );

  pls_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (push),
    .wr_cmd (front_cmd),
    .full   (full),
    .rd     (q_take),
    .valid  (q_valid),
    .rd_cmd (back_cmd)
  );

  pls_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (back_cmd),
    .cmd_take    (q_take),
    .res_valid   (res_valid),
    .res_pop     (pop),
    .res_status  (status),
    .res_removed (removed_value),
    .res_count   (entry_count)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

// ===== sv/pls_checker.sv =====
// pls_checker: port-level checks for positional_list_store, bound to the top level
// depends on pls_pkg
`default_nettype none

module pls_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [1:0]                    status,
  input wire logic [pls_pkg::VALUE_W-1:0]   removed_value,
  input wire logic [pls_pkg::COUNT_W-1:0]   entry_count
);
  import pls_pkg::*;

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered after reset");

  // a stalled item holds its fields
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(removed_value)
                          && $stable(entry_count)))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (entry_count <= COUNT_W'(DEPTH)))
    else $error("entry count above depth");

  // only a successful delete returns a value
  a_removed_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (removed_value == '0))
    else $error("value returned on failed item");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with entries");

endmodule

bind positional_list_store pls_checker #(
  .DEPTH (DEPTH)
) u_pls_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .status        (status),
  .removed_value (removed_value),
  .entry_count   (entry_count)
);

`default_nettype wire

// ===== tb/list_op_checker.sv =====
// list_op_checker: watches the input and result ports of the positional list store,
// keeps its own copy of the list and checks every result field by field
// depends on pls_pkg for the widths and the operation and status codes
`timescale 1ns / 100ps

module list_op_checker #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic                                  full,
  input  logic [2:0]                            operation,
  input  logic signed [pls_pkg::VALUE_W-1:0]    value,
  input  logic [pls_pkg::POS_W-1:0]             position,
  input  logic                                  empty,
  input  logic                                  pop,
  input  logic [1:0]                            status,
  input  logic signed [pls_pkg::VALUE_W-1:0]    removed_value,
  input  logic [pls_pkg::COUNT_W-1:0]           entry_count,
  output int                                    mismatches,
  output int                                    pending
);
  import pls_pkg::*;

  typedef struct {
    logic [1:0]                 status;
    logic signed [VALUE_W-1:0]  removed;
    logic [COUNT_W-1:0]         count;
  } list_outcome_t;

  logic signed [VALUE_W-1:0] list_copy[$];   // head at index 0
  list_outcome_t             outcome_q[$];

  function automatic list_outcome_t apply_list_op(input logic [2:0] op,
                                                  input logic signed [VALUE_W-1:0] val,
                                                  input logic [POS_W-1:0] pos);
    list_outcome_t res;
    int            n;
    int            idx;
    n = list_copy.size();
    res.status  = ST_OK;
    res.removed = '0;
    idx = 0;
    case (op)
      OP_INS_END, OP_INS_HEAD, OP_INS_POS: begin
        if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (op == OP_INS_END) idx = n;
          else if (op == OP_INS_HEAD) idx = 0;
          else if (n == 0 || pos <= 1) idx = 0;
          else if (pos > n) idx = n;
          else idx = pos - 1;
          list_copy.insert(idx, val);
        end
      end
      OP_DEL_HEAD, OP_DEL_END, OP_DEL_POS: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op == OP_DEL_HEAD) idx = 0;
          else if (op == OP_DEL_END) idx = n - 1;
          else if (pos == 0 || pos > n) res.status = ST_RANGE;
          else idx = pos - 1;
          if (res.status == ST_OK) begin
            res.removed = list_copy[idx];
            list_copy.delete(idx);
          end
        end
      end
      default: ;  // spare codes leave the list alone
    endcase
    res.count = COUNT_W'(list_copy.size());
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    list_outcome_t want;
    if (rst) begin
      list_copy.delete();
      outcome_q.delete();
    end else begin
      if (push && !full) outcome_q.push_back(apply_list_op(operation, value, position));
      if (pop && !empty) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected item", 64'd0, {62'd0, status});
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(status));
          if (removed_value !== want.removed)
            report_mismatch("removed_value", 64'(want.removed), 64'(removed_value));
          if (entry_count !== want.count)
            report_mismatch("entry_count", 64'(want.count), 64'(entry_count));
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

// ===== tb/tb_positional_list_store.sv =====
// tb_positional_list_store: drives directed and random list operations into the
// positional list store with random idling on both sides and gives the verdict
// depends on pls_pkg, positional_list_store and list_op_checker
`timescale 1ns / 100ps

module tb_positional_list_store;
  import pls_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 1650;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef enum {MIX_GROW, MIX_EVEN, MIX_SHRINK} op_mix_t;

  logic                       clk;
  logic                       rst;
  logic                       push;
  logic                       full;
  logic [2:0]                 operation;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;
  logic                       empty;
  logic                       pop;
  logic [1:0]                 status;
  logic signed [VALUE_W-1:0]  removed_value;
  logic [COUNT_W-1:0]         entry_count;
  int                         mismatches;
  int                         pending;
  int                         idle_pct;

  positional_list_store #(.DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .operation(operation), .value(value), .position(position),
    .empty(empty), .pop(pop), .status(status),
    .removed_value(removed_value), .entry_count(entry_count)
  );

  list_op_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .operation(operation), .value(value), .position(position),
    .empty(empty), .pop(pop), .status(status),
    .removed_value(removed_value), .entry_count(entry_count),
    .mismatches(mismatches), .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // result side stalls at the same rate as the sender idles
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = ($urandom_range(0, 99) >= idle_pct);
    end
  end

  task automatic send_list_op(input logic [2:0] op, input logic signed [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    operation = op;
    value = val;
    position = pos;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    push = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [2:0] pick_operation(input op_mix_t mix);
    int r;
    int grow_pct;
    r = $urandom_range(0, 99);
    grow_pct = (mix == MIX_GROW) ? 70 : (mix == MIX_SHRINK) ? 27 : 48;
    if (r < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       return OP_INS_END;
        1:       return OP_INS_HEAD;
        default: return OP_INS_POS;
      endcase
    end
    if (r < 97) begin
      case ($urandom_range(0, 2))
        0:       return OP_DEL_HEAD;
        1:       return OP_DEL_END;
        default: return OP_DEL_POS;
      endcase
    end
    return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 16) return POS_W'($urandom);   // wide positions, all bits toggle
    return POS_W'($urandom_range(1, DEPTH + 2));
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'sh7fff_ffff;
    if (r < 6) return 32'sh8000_0000;
    if (r < 8) return '0;
    return $urandom;
  endfunction

  initial begin
    op_mix_t mix;
    rst = 1'b1;
    push = 1'b0;
    operation = OP_INS_END;
    value = '0;
    position = '0;
    idle_pct = 28;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty list, head and end extremes, position corner cases
    send_list_op(OP_DEL_HEAD, 32'sd5, 16'd1);
    send_list_op(OP_DEL_END, 32'sd5, 16'd1);
    send_list_op(OP_DEL_POS, 32'sd5, 16'd1);
    send_list_op(OP_INS_POS, 32'sd11, 16'd7);      // empty list goes to the head
    send_list_op(OP_INS_END, 32'sh7fff_ffff, 16'd0);
    send_list_op(OP_INS_HEAD, 32'sh8000_0000, 16'hffff);
    send_list_op(OP_INS_POS, 32'sd22, 16'd0);
    send_list_op(OP_INS_POS, 32'sd33, 16'd1);
    send_list_op(OP_INS_POS, 32'sd44, 16'd2);
    send_list_op(OP_INS_POS, 32'sd55, 16'd6);      // equal to the count: inside
    send_list_op(OP_INS_POS, -32'sd66, 16'hffff);  // past the count: end
    send_list_op(OP_SPARE_6, 32'sh5555_aaaa, 16'h5555);
    send_list_op(OP_SPARE_7, 32'shaaaa_5555, 16'haaaa);
    send_list_op(OP_DEL_POS, 32'sd0, 16'd0);
    send_list_op(OP_DEL_POS, 32'sd0, 16'hffff);
    send_list_op(OP_DEL_POS, 32'sd0, 16'd9);       // count + 1
    send_list_op(OP_DEL_POS, 32'sd0, 16'd8);       // last entry
    send_list_op(OP_DEL_POS, 32'sd0, 16'd1);
    send_list_op(OP_DEL_POS, 32'sd0, 16'd2);
    send_list_op(OP_DEL_END, 32'sd0, 16'd0);
    send_list_op(OP_DEL_HEAD, 32'sd0, 16'd0);

    // random: alternate growing and shrinking phases to hit full and empty
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i / 120) % 4)
        0:       mix = MIX_GROW;
        1:       mix = MIX_EVEN;
        2:       mix = MIX_SHRINK;
        default: mix = MIX_EVEN;
      endcase
      idle_pct = (i >= 700 && i < 1000) ? 0 : 28;
      if (i == 400) drain_results();
      send_list_op(pick_operation(mix), pick_value(), pick_position());
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
